// ----- sv/assert_macros.svh -----
// Assertion macros shared by the activation unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/act_pkg.sv -----
// Package for the activation unit: widths, mode codes, side-band struct
// and the exp(-t) knot table built at elaboration. No dependencies.
package act_pkg;

	localparam int DataW    = 16;
	localparam int FracBits = 12;
	localparam int TableSeg = 64;
	localparam int SegBits  = 6;
	localparam int KnotW    = 31;
	localparam int ArgW     = 17;
	localparam int QuotW    = 13;
	localparam int NumW     = 43;
	localparam int DenW     = 32;
	localparam int LkqW     = 9;
	localparam int AccW     = DataW + 2;

	localparam longint FxOne  = 64'd1 << FracBits;
	localparam longint Q30One = 64'd1 << 30;

	// |v|/100 as multiply by reciprocal, exact for |v| <= 2^15
	localparam int LeakyMul   = 41944;
	localparam int LeakyShift = 22;
	localparam int LeakyDeriv = (4096 + 50) / 100;

	// Taylor step 16/TableSeg in Q30
	localparam logic [63:0] KnotStep = (64'd16 << 30) / TableSeg;

	localparam logic [2:0] MODE_TANH    = 3'd0;
	localparam logic [2:0] MODE_SIGMOID = 3'd1;
	localparam logic [2:0] MODE_RELU    = 3'd2;
	localparam logic [2:0] MODE_LEAKY   = 3'd3;
	localparam logic [2:0] MODE_LINEAR  = 3'd4;
	localparam logic [2:0] MODE_SOFTMAX = 3'd5;
	localparam logic [2:0] MODE_RESET   = MODE_SIGMOID;

	typedef logic [KnotW-1:0] knot_arr_t [0:TableSeg];

	typedef struct packed {
		logic [2:0]              mode;
		logic signed [DataW-1:0] v;
		logic [QuotW-1:0]        smx;
		logic                    sflag;
		logic [LkqW-1:0]         lkq;
	} side_t;

	// shift-subtract quotient, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dv);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dv) begin
				r    = r - dv;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// K[i] = exp(-16*i/TableSeg) in Q30, via a truncated Taylor sum for the ratio
	function automatic knot_arr_t build_knots();
		knot_arr_t   k;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] kk;
		longint      sum;
		x    = KnotStep;
		term = 64'd1 << 30;
		sum  = 64'd1 << 30;
		for (int n = 1; n <= 30; n++) begin
			term = udiv64((term * x) >> 30, 64'(n));
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		kk   = 64'd1 << 30;
		k[0] = kk[KnotW-1:0];
		for (int i = 1; i <= TableSeg; i++) begin
			kk   = (kk * 64'(sum) + (64'd1 << 29)) >> 30;
			k[i] = kk[KnotW-1:0];
		end
		return k;
	endfunction

	localparam knot_arr_t Knots = build_knots();

endpackage

// ----- sv/act_exp.sv -----
// Front end of the activation unit: exp(-t) table interpolation and
// divider operand set-up, four pipeline stages. Depends on act_pkg.
module act_exp import act_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [2:0]              mode,
	input  logic signed [DataW-1:0] v,
	input  logic signed [DataW-1:0] m,
	output logic                    valid_s4,
	output logic [NumW-1:0]         num_s4,
	output logic [DenW-1:0]         den_s4,
	output side_t                   side_s4
);

	// stage 1: exp argument
	logic signed [DataW:0] diff;
	logic [DataW-1:0]      mag;
	logic [ArgW-1:0]       t;
	logic                  sflag;

	always_comb begin
		diff  = {v[DataW-1], v} - {m[DataW-1], m};
		mag   = v[DataW-1] ? DataW'(-v) : v;
		sflag = (mode == MODE_SOFTMAX) && (diff > 0);
		unique case (mode)
			MODE_TANH:    t = {mag, 1'b0};
			MODE_SOFTMAX: t = (diff > 0) ? '0 : ArgW'(-diff);
			default:      t = {1'b0, mag};
		endcase
	end

	logic                    valid_s1, valid_s2, valid_s3;
	logic [2:0]              mode_s1, mode_s2, mode_s3;
	logic signed [DataW-1:0] v_s1, v_s2, v_s3;
	logic                    sflag_s1, sflag_s2, sflag_s3;
	logic [ArgW-1:0]         t_s1;
	logic [DataW-1:0]        mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		v_s1     <= v;
		sflag_s1 <= sflag;
		t_s1     <= t;
		mag_s1   <= mag;
	end

	// stage 2: knot lookup, leaky quotient
	logic [SegBits-1:0] idx;
	logic [SegBits:0]   idx_nx;
	logic [31:0]        lkprod;
	logic [KnotW-1:0]   ka_s2, kb_s2, ka_s3;
	logic [9:0]         q_s2;
	logic               zero_s2, zero_s3;
	logic [LkqW-1:0]    lkq_s2, lkq_s3;

	always_comb begin
		idx    = t_s1[SegBits+9:10];
		idx_nx = {1'b0, idx} + 1'b1;
		lkprod = 32'(mag_s1) * 32'(LeakyMul);
	end

	always_ff @(posedge clk) begin
		ka_s2    <= Knots[idx];
		kb_s2    <= Knots[idx_nx];
		q_s2     <= t_s1[9:0];
		zero_s2  <= t_s1[ArgW-1];
		lkq_s2   <= lkprod[LeakyShift+LkqW-1:LeakyShift];
		mode_s2  <= mode_s1;
		v_s2     <= v_s1;
		sflag_s2 <= sflag_s1;
	end

	// stage 3: slope times fraction
	logic [KnotW-1:0]    delta;
	logic [KnotW+9:0]    prod_s3;

	assign delta = ka_s2 - kb_s2;

	always_ff @(posedge clk) begin
		prod_s3  <= (KnotW+10)'(delta) * (KnotW+10)'(q_s2);
		ka_s3    <= ka_s2;
		zero_s3  <= zero_s2;
		lkq_s3   <= lkq_s2;
		mode_s3  <= mode_s2;
		v_s3     <= v_s2;
		sflag_s3 <= sflag_s2;
	end

	// stage 4: e, divider operands, softmax result
	logic [KnotW-1:0] e;
	logic [NumW-1:0]  num;
	logic [DenW-1:0]  den;
	logic [DenW-1:0]  rnd;
	side_t            side;

	always_comb begin
		e   = zero_s3 ? '0 : ka_s3 - KnotW'(prod_s3 >> 10);
		den = DenW'(Q30One) + DenW'(e);
		rnd = DenW'(e) + (DenW'(1) << (29 - FracBits));
		unique case (mode_s3)
			MODE_TANH: num = NumW'(KnotW'(Q30One) - e) << FracBits;
			default:   num = v_s3[DataW-1] ? (NumW'(e) << FracBits)
				: (NumW'(1) << (30 + FracBits));
		endcase
		side.mode  = mode_s3;
		side.v     = v_s3;
		side.smx   = QuotW'(rnd >> (30 - FracBits));
		side.sflag = sflag_s3;
		side.lkq   = lkq_s3;
	end

	always_ff @(posedge clk) begin
		num_s4  <= num;
		den_s4  <= den;
		side_s4 <= side;
	end

endmodule

// ----- sv/act_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for the
// tanh and sigmoid quotients. Depends on act_pkg and assert_macros.svh.
`include "assert_macros.svh"

module act_div import act_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NumW-1:0]  num,
	input  logic [DenW-1:0]  den,
	input  side_t            side,
	output logic             out_valid,
	output logic [QuotW-1:0] quot,
	output side_t            out_side
);

	logic             valid_s [0:QuotW];
	logic [NumW-1:0]  rem_s   [0:QuotW];
	logic [DenW-1:0]  den_s   [0:QuotW];
	logic [QuotW-1:0] quot_s  [0:QuotW];
	side_t            side_s  [0:QuotW];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = num;
	assign den_s[0]   = den;
	assign quot_s[0]  = '0;
	assign side_s[0]  = side;

	for (genvar j = 0; j < QuotW; j++) begin : g_step
		localparam int K = QuotW - 1 - j;
		logic [NumW:0] trial;
		logic          ge;

		always_comb begin
			trial = (NumW+1)'(den_s[j]) << K;
			ge    = {1'b0, rem_s[j]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[j+1] <= 1'b0;
			else
				valid_s[j+1] <= valid_s[j];
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= ge ? rem_s[j] - trial[NumW-1:0] : rem_s[j];
			quot_s[j+1] <= quot_s[j] | (QuotW'(ge) << K);
			den_s[j+1]  <= den_s[j];
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = valid_s[QuotW];
	assign quot      = quot_s[QuotW];
	assign out_side  = side_s[QuotW];

	// numerator never exceeds the divisor scaled by one
	`ASSERT_IMPLIES(a_quot_range, clk, arst_n, out_valid, quot <= QuotW'(FxOne), "quotient above one")

endmodule

// ----- sv/act_out.sv -----
// Back end: selects the activated value per mode, forms the derivative
// and saturates both; three stages. Depends on act_pkg, assert_macros.svh.
`include "assert_macros.svh"

module act_out import act_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [QuotW-1:0]        quot,
	input  side_t                   side,
	output logic                    valid_sc,
	output logic signed [DataW-1:0] activated_sc,
	output logic signed [DataW-1:0] derivative_sc,
	output logic                    saturated_sc
);

	localparam int ProdW = 2 * AccW;

	// stage A: activated value
	logic signed [AccW-1:0] a, dconst, qs;
	logic                   mul, tanh;
	logic                   neg;

	always_comb begin
		neg    = side.v[DataW-1];
		qs     = $signed(AccW'(quot));
		mul    = 1'b1;
		tanh   = 1'b0;
		dconst = AccW'(FxOne);
		unique case (side.mode)
			MODE_TANH: begin
				a    = neg ? -qs : qs;
				tanh = 1'b1;
			end
			MODE_RELU: begin
				a      = neg ? '0 : AccW'(side.v);
				mul    = 1'b0;
				dconst = neg ? '0 : AccW'(FxOne);
			end
			MODE_LEAKY: begin
				a      = neg ? -$signed(AccW'(side.lkq)) : AccW'(side.v);
				mul    = 1'b0;
				dconst = neg ? AccW'(LeakyDeriv) : AccW'(FxOne);
			end
			MODE_LINEAR: begin
				a   = AccW'(side.v);
				mul = 1'b0;
			end
			MODE_SOFTMAX: a = $signed(AccW'(side.smx));
			default:      a = qs;
		endcase
	end

	logic                   valid_sa, valid_sb;
	logic signed [AccW-1:0] a_sa, a_sb, dconst_sa, dconst_sb;
	logic                   mul_sa, mul_sb, tanh_sa, tanh_sb, sflag_sa, sflag_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
			valid_sb <= 1'b0;
			valid_sc <= 1'b0;
		end else begin
			valid_sa <= in_valid;
			valid_sb <= valid_sa;
			valid_sc <= valid_sb;
		end
	end

	always_ff @(posedge clk) begin
		a_sa      <= a;
		dconst_sa <= dconst;
		mul_sa    <= mul;
		tanh_sa   <= tanh;
		sflag_sa  <= side.sflag;
	end

	// stage B: a*a for tanh, a*(1-a) for the logistic family
	logic signed [AccW-1:0]  b;
	logic signed [ProdW-1:0] prod_sb;

	assign b = tanh_sa ? a_sa : AccW'(FxOne) - a_sa;

	always_ff @(posedge clk) begin
		prod_sb   <= ProdW'(a_sa) * ProdW'(b);
		a_sb      <= a_sa;
		dconst_sb <= dconst_sa;
		mul_sb    <= mul_sa;
		tanh_sb   <= tanh_sa;
		sflag_sb  <= sflag_sa;
	end

	// stage C: derivative and clipping
	localparam longint Hi = (64'sd1 <<< (DataW - 1)) - 1;
	localparam longint Lo = -(64'sd1 <<< (DataW - 1));

	logic signed [ProdW-1:0] dw, aw;
	logic                    clip_a, clip_d;
	logic signed [DataW-1:0] a_c, d_c;

	always_comb begin
		if (tanh_sb)
			dw = ProdW'(FxOne) - (prod_sb >>> FracBits);
		else if (mul_sb)
			dw = prod_sb >>> FracBits;
		else
			dw = ProdW'(dconst_sb);
		aw     = ProdW'(a_sb);
		clip_a = (aw > ProdW'(Hi)) || (aw < ProdW'(Lo));
		clip_d = (dw > ProdW'(Hi)) || (dw < ProdW'(Lo));
		a_c    = clip_a ? (aw[ProdW-1] ? DataW'(Lo) : DataW'(Hi)) : aw[DataW-1:0];
		d_c    = clip_d ? (dw[ProdW-1] ? DataW'(Lo) : DataW'(Hi)) : dw[DataW-1:0];
	end

	always_ff @(posedge clk) begin
		activated_sc  <= a_c;
		derivative_sc <= d_c;
		saturated_sc  <= sflag_sb | clip_a | clip_d;
	end

	`ASSERT_IMPLIES(a_deriv_sign, clk, arst_n, valid_sc, !derivative_sc[DataW-1], "negative derivative")
	`ASSERT_NEXT(a_softmax_clamp, clk, arst_n, valid_sb && sflag_sb, saturated_sc && (derivative_sc == '0), "softmax clamp lost")

endmodule

// ----- sv/nn_activation_with_derivative.sv -----
// Activation unit with derivative: tanh, sigmoid, relu, leaky relu, linear, softmax exp.
// From accepting start to the done strobe, an item passes the 4 exp stages,
// 13 divider stages and 3 output stages; throughput one item per cycle.
// busy is never raised; the receiver cannot stall and none is needed.
// Reset clears the stage valid bits and sets the mode to sigmoid.
// Depends on act_pkg, act_exp, act_div and act_out.
module nn_activation_with_derivative import act_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [DataW-1:0] pre_activation,
	input  logic signed [DataW-1:0] softmax_offset,
	input  logic                    activation_mode_we,
	input  logic [2:0]              activation_mode_wdata,
	output logic                    done,
	output logic signed [DataW-1:0] activated,
	output logic signed [DataW-1:0] derivative,
	output logic                    saturated
);

	logic [2:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_RESET;
		else if (activation_mode_we)
			mode_q <= activation_mode_wdata;
	end

	assign busy = 1'b0;

	logic            exp_valid, div_valid;
	logic [NumW-1:0] num;
	logic [DenW-1:0] den;
	side_t           exp_side, div_side;
	logic [QuotW-1:0] quot;

	act_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.mode     (mode_q),
		.v        (pre_activation),
		.m        (softmax_offset),
		.valid_s4 (exp_valid),
		.num_s4   (num),
		.den_s4   (den),
		.side_s4  (exp_side)
	);

	act_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exp_valid),
		.num       (num),
		.den       (den),
		.side      (exp_side),
		.out_valid (div_valid),
		.quot      (quot),
		.out_side  (div_side)
	);

	act_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_valid),
		.quot          (quot),
		.side          (div_side),
		.valid_sc      (done),
		.activated_sc  (activated),
		.derivative_sc (derivative),
		.saturated_sc  (saturated)
	);

endmodule

// ----- verif/nn_activation_with_derivative_tb.sv -----
// Self-checking testbench for nn_activation_with_derivative: a directed table,
// then random items per mode, checked against a predictor of the activation unit.
// Depends on act_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module nn_activation_with_derivative_tb;
	import act_pkg::*;

	localparam int WatchLimit = 5000;

	typedef struct {
		logic signed [15:0] act;
		logic signed [15:0] deriv;
		logic               sat;
	} act_result_t;

	typedef struct {
		logic [2:0]         mode;
		logic signed [15:0] v;
		logic signed [15:0] m;
		bit                 typed;
		act_result_t        res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] pre_activation = '0;
	logic signed [15:0] softmax_offset = '0;
	logic               activation_mode_we = 1'b0;
	logic [2:0]         activation_mode_wdata = '0;
	logic               done;
	logic signed [15:0] activated;
	logic signed [15:0] derivative;
	logic               saturated;

	logic [63:0] exp_knots [0:64];
	logic [2:0]  cur_mode;
	act_result_t pending_results [$];
	int          n_errors = 0;
	int          idle_cycles = 0;
	bit          no_gaps = 1'b0;

	nn_activation_with_derivative uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pre_activation(pre_activation), .softmax_offset(softmax_offset),
		.activation_mode_we(activation_mode_we),
		.activation_mode_wdata(activation_mode_wdata),
		.done(done), .activated(activated), .derivative(derivative),
		.saturated(saturated)
	);

	always #5 clk = ~clk;

	// exp(-16*i/64) in Q30, ratio from a Taylor series truncated after the x^30 term
	task automatic make_knots();
		logic [63:0] x;
		logic [63:0] term;
		longint      ratio;
		x = (64'd16 << 30) / 64;
		term = 64'd1 << 30;
		ratio = 64'd1 << 30;
		for (int n = 1; n <= 30; n++) begin
			term = ((term * x) >> 30) / n;
			if (n & 1)
				ratio -= longint'(term);
			else
				ratio += longint'(term);
		end
		if (ratio < 0)
			ratio = 0;
		exp_knots[0] = 64'd1 << 30;
		for (int i = 1; i <= 64; i++)
			exp_knots[i] = (exp_knots[i-1] * 64'(ratio) + (64'd1 << 29)) >> 30;
	endtask

	function automatic logic [63:0] exp_neg(logic [63:0] t);
		logic [63:0] p;
		logic [63:0] seg;
		logic [63:0] frac;
		p = t * 64;
		seg = p >> 16;
		frac = p & 64'hFFFF;
		if (seg >= 64)
			return 0;
		return exp_knots[seg] - (((exp_knots[seg] - exp_knots[seg+1]) * frac) >> 16);
	endfunction

	function automatic longint sat16(longint x, ref bit flag);
		if (x > 32767) begin
			flag = 1;
			return 32767;
		end
		if (x < -32768) begin
			flag = 1;
			return -32768;
		end
		return x;
	endfunction

	function automatic act_result_t activation_of(logic [2:0] mode, logic signed [15:0] v,
			logic signed [15:0] m);
		act_result_t r;
		longint      vi;
		longint      a;
		longint      d;
		longint      diff;
		logic [63:0] mag;
		logic [63:0] e;
		logic [63:0] one30;
		bit          flag;
		vi = v;
		mag = (vi < 0) ? -vi : vi;
		one30 = 64'd1 << 30;
		flag = 0;
		case (mode)
			MODE_TANH: begin
				e = exp_neg(2 * mag);
				a = longint'(((one30 - e) << 12) / (one30 + e));
				if (vi < 0)
					a = -a;
				d = 4096 - longint'(64'(a * a) >> 12);
			end
			MODE_RELU: begin
				a = (vi >= 0) ? vi : 0;
				d = (vi >= 0) ? 4096 : 0;
			end
			MODE_LEAKY: begin
				a = (vi >= 0) ? vi : vi / 100;
				d = (vi >= 0) ? 4096 : (4096 + 50) / 100;
			end
			MODE_LINEAR: begin
				a = vi;
				d = 4096;
			end
			MODE_SOFTMAX: begin
				diff = vi - longint'(m);
				if (diff > 0) begin
					flag = 1;
					diff = 0;
				end
				e = exp_neg(64'(-diff));
				a = longint'((e + (64'd1 << 17)) >> 18);
				d = longint'((64'(a) * 64'(4096 - a)) >> 12);
			end
			default: begin
				// sigmoid, also for the unused mode codes
				e = exp_neg(mag);
				if (vi >= 0)
					a = longint'((one30 << 12) / (one30 + e));
				else
					a = longint'((e << 12) / (one30 + e));
				d = longint'((64'(a) * 64'(4096 - a)) >> 12);
			end
		endcase
		a = sat16(a, flag);
		d = sat16(d, flag);
		r.act = a[15:0];
		r.deriv = d[15:0];
		r.sat = flag;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance, or later after a random gap
	task automatic send_item(logic signed [15:0] v, logic signed [15:0] m, bit typed,
			act_result_t res);
		start <= 1'b1;
		pre_activation <= v;
		softmax_offset <= m;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(typed ? res : activation_of(cur_mode, v, m));
		@(negedge clk);
		if (!no_gaps && $urandom_range(99) < 13) begin
			start <= 1'b0;
			pre_activation <= 16'($urandom);
			softmax_offset <= 16'($urandom);
			repeat ($urandom_range(1, 4))
				@(negedge clk);
		end
	endtask

	// mode register only changes with the pipe empty
	task automatic set_mode(logic [2:0] mode);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (25)
			@(negedge clk);
		activation_mode_we <= 1'b1;
		activation_mode_wdata <= mode;
		@(negedge clk);
		activation_mode_we <= 1'b0;
		activation_mode_wdata <= 3'($urandom);
		cur_mode = mode;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		act_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing outstanding: act=%0d", activated);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				if (activated !== want.act) begin
					$error("activated: expected %0d, got %0d", want.act, activated);
					n_errors++;
				end
				if (derivative !== want.deriv) begin
					$error("derivative: expected %0d, got %0d", want.deriv, derivative);
					n_errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0d, got %0d", want.sat, saturated);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || activation_mode_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	row_t dir_rows [] = '{
		'{MODE_SIGMOID, 16'sd0, 16'sd0, 1, '{16'sd2048, 16'sd1024, 1'b0}},
		'{MODE_SIGMOID, 16'sh7FFF, 16'sd0, 0, '{0, 0, 0}},
		'{MODE_SIGMOID, -16'sd32768, 16'sd0, 0, '{0, 0, 0}},
		'{MODE_TANH, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd4096, 1'b0}},
		'{MODE_TANH, 16'sh7FFF, 16'sd0, 0, '{0, 0, 0}},
		'{MODE_TANH, -16'sd32768, 16'sd0, 0, '{0, 0, 0}},
		'{MODE_TANH, -16'sd2000, 16'sd0, 0, '{0, 0, 0}},
		'{MODE_RELU, 16'sh7FFF, 16'sd0, 1, '{16'sh7FFF, 16'sd4096, 1'b0}},
		'{MODE_RELU, -16'sd32768, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b0}},
		'{MODE_RELU, 16'sd0, 16'sd0, 1, '{16'sd0, 16'sd4096, 1'b0}},
		'{MODE_LEAKY, -16'sd32768, 16'sd0, 1, '{-16'sd327, 16'sd41, 1'b0}},
		'{MODE_LEAKY, -16'sd99, 16'sd0, 1, '{16'sd0, 16'sd41, 1'b0}},
		'{MODE_LEAKY, 16'sh7FFF, 16'sd0, 1, '{16'sh7FFF, 16'sd4096, 1'b0}},
		'{MODE_LINEAR, -16'sd32768, 16'sd0, 1, '{-16'sd32768, 16'sd4096, 1'b0}},
		'{MODE_LINEAR, 16'sh7FFF, 16'sd0, 1, '{16'sh7FFF, 16'sd4096, 1'b0}},
		'{MODE_SOFTMAX, 16'sd100, 16'sd0, 1, '{16'sd4096, 16'sd0, 1'b1}},
		'{MODE_SOFTMAX, 16'sh7FFF, -16'sd32768, 1, '{16'sd4096, 16'sd0, 1'b1}},
		'{MODE_SOFTMAX, 16'sd500, 16'sd500, 1, '{16'sd4096, 16'sd0, 1'b0}},
		'{MODE_SOFTMAX, -16'sd32768, 16'sh7FFF, 0, '{0, 0, 0}},
		'{MODE_SOFTMAX, -16'sd4096, 16'sd0, 0, '{0, 0, 0}},
		'{3'd6, -16'sd3000, 16'sd0, 0, '{0, 0, 0}},
		'{3'd7, 16'sd3000, 16'sd0, 0, '{0, 0, 0}}
	};

	logic [2:0] phase_modes [10] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd5, 3'd0};

	initial begin
		logic signed [15:0] v;
		logic signed [15:0] m;
		act_result_t        none;
		none = '{0, 0, 0};
		make_knots();
		cur_mode = MODE_SIGMOID;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != cur_mode)
				set_mode(dir_rows[i].mode);
			send_item(dir_rows[i].v, dir_rows[i].m, dir_rows[i].typed, dir_rows[i].res);
		end

		foreach (phase_modes[p]) begin
			set_mode(phase_modes[p]);
			for (int k = 0; k < 80; k++) begin
				no_gaps = (p == 4);
				case ($urandom_range(3))
					0: v = 16'($urandom);
					1: v = 16'($urandom_range(0, 16000)) - 16'sd8000;
					2: v = 16'($urandom_range(0, 2000)) - 16'sd1000;
					default: v = 16'($urandom_range(0, 200)) - 16'sd100;
				endcase
				// softmax: offset mostly at or above the value, as a layer max would be
				if (cur_mode == MODE_SOFTMAX && $urandom_range(9) < 8)
					m = (v > 16'sd32767 - 16'sd20000) ? 16'sh7FFF :
						v + 16'($urandom_range(0, 20000));
				else
					m = 16'($urandom);
				send_item(v, m, 0, none);
			end
		end
		no_gaps = 0;
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
